// File: hw/rtl/heartbeat_frame_checker_core_macros.svh
// Assertion macros used by the heartbeat frame checker's port-level checker.
`ifndef HEARTBEAT_FRAME_CHECKER_CORE_MACROS_SVH
`define HEARTBEAT_FRAME_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/hfc_pkg.sv
// Types, constants and helper functions for the heartbeat frame checker.
package hfc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 5;

  // Frame layout, byte positions
  localparam logic [POS_W-1:0] FRAME_BYTES  = 5'd28;
  localparam logic [POS_W-1:0] LAST_POS     = 5'd27;
  localparam logic [POS_W-1:0] MAGIC_END    = 5'd2;
  localparam logic [POS_W-1:0] POS_VERSION  = 5'd2;
  localparam logic [POS_W-1:0] POS_TYPE     = 5'd3;
  localparam logic [POS_W-1:0] FEED_END     = 5'd8;
  localparam logic [POS_W-1:0] SEQ_END      = 5'd16;
  localparam logic [POS_W-1:0] CRC_BYTES    = 5'd24;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  localparam int unsigned NUM_TYPES = 5;
  localparam int unsigned TYPES_W   = NUM_TYPES * BYTE_W;

  // Configuration reset values
  localparam logic [15:0]        MAGIC_RESET   = 16'h0000;
  localparam logic [7:0]         VERSION_RESET = 8'h01;
  localparam logic [TYPES_W-1:0] TYPES_RESET   = 40'h0504030201;

  typedef enum logic [1:0] {
    CFG_MAGIC   = 2'd0,
    CFG_VERSION = 2'd1,
    CFG_TYPES   = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_MAGIC   = 3'd1,
    ERR_VERSION = 3'd2,
    ERR_TYPE    = 3'd3,
    ERR_CRC     = 3'd4
  } err_code_t;

  // One byte of reflected CRC-32, bit at a time.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                           input logic [BYTE_W-1:0] b);
    logic [31:0] c;
    c = crc ^ {24'h000000, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic type_known(input logic [TYPES_W-1:0] types,
                                      input logic [BYTE_W-1:0] t);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_TYPES; k++) begin
      if (types[k*BYTE_W +: BYTE_W] == t) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// File: hw/rtl/heartbeat_frame_checker_core.sv
// Heartbeat frame checker: takes one frame byte per request and, after the
// 28th byte, delivers one result with the unpacked fields and an error code.
// Throughput is one byte per clock unless a held result stalls input. Each byte
// updates the CRC-32 and the field shift registers in the cycle it is accepted;
// the checks run in the same cycle as the last byte and land in the result
// register, so a result is valid on the cycle after byte 27 is accepted. The
// result register holds a result while the consumer stalls; input keeps flowing
// then, and only a last-position byte waits until the held result is taken. A
// byte with frame_start high restarts the frame and drops any partial frame.
// Configuration writes are always accepted and take effect on the next cycle.
module heartbeat_frame_checker_core (
  input  logic                               clk,
  input  logic                               rst,
  // byte input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         data_byte,
  input  logic                               frame_start,
  // result output
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               frame_ok,
  output logic [2:0]                         error_code,
  output logic [7:0]                         msg_type,
  output logic [31:0]                        feed_id,
  output logic [63:0]                        sequence_res,
  output logic signed [63:0]                 timestamp_res,
  output logic [31:0]                        frame_crc,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [hfc_pkg::TYPES_W-1:0]        cfg_data
);

  logic [15:0]                  expected_magic;
  logic [7:0]                   expected_version;
  logic [hfc_pkg::TYPES_W-1:0]  known_types;

  logic [hfc_pkg::POS_W-1:0]    byte_position;
  logic [31:0]                  running_crc;
  logic [15:0]                  magic_shift;
  logic [7:0]                   version_seen;
  logic [7:0]                   type_seen;
  logic [31:0]                  feed_shift;
  logic [63:0]                  sequence_shift;
  logic [63:0]                  timestamp_shift;
  logic [31:0]                  crc_shift;

  logic [hfc_pkg::POS_W-1:0]    pos;
  logic [31:0]                  crc_base;
  logic [31:0]                  running_crc_next;
  logic [31:0]                  crc_shift_next;
  logic                         in_accept;
  logic                         last_byte;
  hfc_pkg::err_code_t           err_next;

  assign cfg_ready = 1'b1;

  // Hold a last byte only while a finished result is still waiting.
  assign in_ready  = !out_valid || out_ready || (byte_position != hfc_pkg::LAST_POS);
  assign in_accept = in_valid && in_ready;

  always_comb begin
    pos = byte_position;
    if (frame_start || (byte_position >= hfc_pkg::FRAME_BYTES)) begin
      pos = '0;
    end
    crc_base = (pos == '0) ? hfc_pkg::CRC_ONES : running_crc;
    running_crc_next = (pos < hfc_pkg::CRC_BYTES) ?
                       hfc_pkg::crc_byte(crc_base, data_byte) : crc_base;
    crc_shift_next = {crc_shift[23:0], data_byte};
    last_byte = (pos == hfc_pkg::LAST_POS);
  end

  // Checks, first failure wins.
  always_comb begin
    priority if (magic_shift != expected_magic) begin
      err_next = hfc_pkg::ERR_MAGIC;
    end else if (version_seen != expected_version) begin
      err_next = hfc_pkg::ERR_VERSION;
    end else if (!hfc_pkg::type_known(known_types, type_seen)) begin
      err_next = hfc_pkg::ERR_TYPE;
    end else if ((running_crc ^ hfc_pkg::CRC_ONES) != crc_shift_next) begin
      err_next = hfc_pkg::ERR_CRC;
    end else begin
      err_next = hfc_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic   <= hfc_pkg::MAGIC_RESET;
      expected_version <= hfc_pkg::VERSION_RESET;
      known_types      <= hfc_pkg::TYPES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hfc_pkg::CFG_MAGIC:   expected_magic   <= cfg_data[15:0];
        hfc_pkg::CFG_VERSION: expected_version <= cfg_data[7:0];
        hfc_pkg::CFG_TYPES:   known_types      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      running_crc     <= hfc_pkg::CRC_ONES;
      magic_shift     <= '0;
      version_seen    <= '0;
      type_seen       <= '0;
      feed_shift      <= '0;
      sequence_shift  <= '0;
      timestamp_shift <= '0;
      crc_shift       <= '0;
    end else if (in_accept) begin
      byte_position <= last_byte ? '0 : pos + 5'd1;
      running_crc   <= running_crc_next;
      priority if (pos < hfc_pkg::MAGIC_END) begin
        magic_shift <= {magic_shift[7:0], data_byte};
      end else if (pos == hfc_pkg::POS_VERSION) begin
        version_seen <= data_byte;
      end else if (pos == hfc_pkg::POS_TYPE) begin
        type_seen <= data_byte;
      end else if (pos < hfc_pkg::FEED_END) begin
        feed_shift <= {feed_shift[23:0], data_byte};
      end else if (pos < hfc_pkg::SEQ_END) begin
        sequence_shift <= {sequence_shift[55:0], data_byte};
      end else if (pos < hfc_pkg::CRC_BYTES) begin
        timestamp_shift <= {timestamp_shift[55:0], data_byte};
      end else begin
        crc_shift <= crc_shift_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && last_byte) begin
      frame_ok      <= (err_next == hfc_pkg::ERR_NONE);
      error_code    <= err_next;
      msg_type      <= type_seen;
      feed_id       <= feed_shift;
      sequence_res  <= sequence_shift;
      timestamp_res <= timestamp_shift;
      frame_crc     <= crc_shift_next;
    end
  end

endmodule

// File: hw/rtl/hfc_checker.sv
// Port-level assertions for the heartbeat frame checker, bound to the core.
`include "heartbeat_frame_checker_core_macros.svh"

module hfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        frame_ok,
  input logic [2:0]  error_code,
  input logic [31:0] frame_crc
);

  `HFC_ASSERT_NOW(a_ok_matches_code, clk, rst, out_valid, frame_ok == (error_code == hfc_pkg::ERR_NONE), "frame_ok disagrees with error_code")

  `HFC_ASSERT_NOW(a_code_range, clk, rst, out_valid, error_code <= hfc_pkg::ERR_CRC, "error_code out of range")

  `HFC_ASSERT_NOW(a_result_from_request, clk, rst, $rose(out_valid), $past(in_valid && in_ready), "result appeared without an input request")

  `HFC_ASSERT_NEXT(a_result_held, clk, rst, out_valid && !out_ready, out_valid && $stable(frame_crc) && $stable(error_code), "stalled result changed")

endmodule

bind heartbeat_frame_checker_core hfc_checker u_hfc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .frame_ok   (frame_ok),
  .error_code (error_code),
  .frame_crc  (frame_crc)
);

// File: tb/heartbeat_frame_checker_core_tb.sv
// Self-checking testbench for the heartbeat frame checker core.
module heartbeat_frame_checker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_BYTES = 120;

  typedef struct packed {
    logic               ok;
    hfc_pkg::err_code_t code;
    logic [7:0]         mtype;
    logic [31:0]        feed;
    logic [63:0]        seq;
    logic [63:0]        ts;
    logic [31:0]        fcs;
  } frame_result_t;

  // One directed frame: header fields, CRC corruption, start mark, length of a
  // dropped partial frame sent ahead of it, and an optional hand-typed code.
  typedef struct packed {
    logic [15:0]        mg;
    logic [7:0]         ver;
    logic [7:0]         ty;
    logic [31:0]        feed;
    logic [63:0]        seq;
    logic [63:0]        ts;
    logic [31:0]        flip;
    logic               mark;
    logic [4:0]         cut;
    logic               pinned;
    hfc_pkg::err_code_t code;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          data_byte;
  logic                frame_start;
  logic                out_valid;
  logic                out_ready;
  logic                frame_ok;
  logic [2:0]          error_code;
  logic [7:0]          msg_type;
  logic [31:0]         feed_id;
  logic [63:0]         sequence_res;
  logic signed [63:0]  timestamp_res;
  logic [31:0]         frame_crc;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [hfc_pkg::TYPES_W-1:0] cfg_data;

  heartbeat_frame_checker_core u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .frame_start   (frame_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_ok      (frame_ok),
    .error_code    (error_code),
    .msg_type      (msg_type),
    .feed_id       (feed_id),
    .sequence_res  (sequence_res),
    .timestamp_res (timestamp_res),
    .frame_crc     (frame_crc),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Register copies and deframer state, starting from their reset values
  logic [15:0]                 cfg_magic = hfc_pkg::MAGIC_RESET;
  logic [7:0]                  cfg_ver   = hfc_pkg::VERSION_RESET;
  logic [hfc_pkg::TYPES_W-1:0] cfg_types = hfc_pkg::TYPES_RESET;

  logic [4:0]  trk_pos   = '0;
  logic [31:0] trk_crc   = '1;
  logic [15:0] trk_magic = '0;
  logic [7:0]  trk_ver   = '0;
  logic [7:0]  trk_type  = '0;
  logic [31:0] trk_feed  = '0;
  logic [63:0] trk_seq   = '0;
  logic [63:0] trk_ts    = '0;
  logic [31:0] trk_fcs   = '0;

  frame_result_t      pending_frames[$];
  bit                 pin_en = 1'b0;
  hfc_pkg::err_code_t pin_code = hfc_pkg::ERR_NONE;
  bit                 tx_idle = 1'b1;
  bit                 rx_idle = 1'b1;
  int unsigned        hold_cycles = 0;
  int unsigned        cycles = 0;
  int unsigned        bytes_sent = 0;
  int unsigned        frames_seen = 0;
  int unsigned        mismatches = 0;
  int unsigned        settings_used = 1;
  int unsigned        holds_done = 0;
  int unsigned        drains_done = 0;
  int unsigned        code_count[5] = '{0, 0, 0, 0, 0};

  dir_row_t dir_rows [0:14] = '{
    '{16'h0000, 8'h01, 8'h01, 32'h0, 64'h0, 64'h0,
      32'h0, 1'b1, 5'd0, 1'b1, hfc_pkg::ERR_NONE},
    '{16'h0000, 8'h01, 8'h05, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      64'h7FFF_FFFF_FFFF_FFFF, 32'h0, 1'b1, 5'd0, 1'b1, hfc_pkg::ERR_NONE},
    '{16'h0000, 8'h01, 8'h03, 32'h0000_0001, 64'h1, 64'h8000_0000_0000_0000,
      32'h0, 1'b1, 5'd0, 1'b1, hfc_pkg::ERR_NONE},
    '{16'hFFFF, 8'h01, 8'h01, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555,
      64'hAAAA_AAAA_AAAA_AAAA, 32'h0, 1'b1, 5'd0, 1'b1, hfc_pkg::ERR_MAGIC},
    '{16'h8001, 8'hFF, 8'h00, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h5555_5555_5555_5555, 32'h1, 1'b1, 5'd0, 1'b1, hfc_pkg::ERR_MAGIC},
    '{16'h0000, 8'hFF, 8'h01, 32'h0, 64'h0, 64'h0,
      32'h0, 1'b1, 5'd0, 1'b1, hfc_pkg::ERR_VERSION},
    '{16'h0000, 8'h00, 8'hFF, 32'h0, 64'h0, 64'h0,
      32'hFFFF_FFFF, 1'b1, 5'd0, 1'b1, hfc_pkg::ERR_VERSION},
    '{16'h0000, 8'h01, 8'h00, 32'h0, 64'h0, 64'h0,
      32'h0, 1'b1, 5'd0, 1'b1, hfc_pkg::ERR_TYPE},
    '{16'h0000, 8'h01, 8'hFF, 32'h0, 64'h0, 64'h0,
      32'h1, 1'b1, 5'd0, 1'b1, hfc_pkg::ERR_TYPE},
    '{16'h0000, 8'h01, 8'h06, 32'h0, 64'h0, 64'h0,
      32'h0, 1'b1, 5'd0, 1'b1, hfc_pkg::ERR_TYPE},
    '{16'h0000, 8'h01, 8'h02, 32'h0, 64'h0, 64'h0,
      32'h8000_0000, 1'b1, 5'd0, 1'b1, hfc_pkg::ERR_CRC},
    '{16'h0000, 8'h01, 8'h04, 32'h0, 64'h0, 64'h0,
      32'h1, 1'b1, 5'd0, 1'b1, hfc_pkg::ERR_CRC},
    '{16'h0000, 8'h01, 8'h02, 32'h1234_5678, 64'h1, 64'h2,
      32'h0, 1'b1, 5'd13, 1'b1, hfc_pkg::ERR_NONE},
    '{16'h0000, 8'h01, 8'h01, 32'h0, 64'h0, 64'h0,
      32'h0, 1'b0, 5'd0, 1'b1, hfc_pkg::ERR_NONE},
    '{16'h0000, 8'h01, 8'h05, 32'h0123_4567, 64'h0123_4567_89AB_CDEF,
      64'hFEDC_BA98_7654_3210, 32'h0, 1'b1, 5'd27, 1'b0, hfc_pkg::ERR_NONE}
  };

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) x = (x >> 1) ^ (32'hEDB8_8320 & {32{x[0]}});
    return x;
  endfunction

  function automatic logic type_ok(input logic [hfc_pkg::TYPES_W-1:0] types,
                                   input logic [7:0] t);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < hfc_pkg::NUM_TYPES; i++) if (types[8*i +: 8] == t) hit = 1'b1;
    return hit;
  endfunction

  // Pack the header fields big-endian and append the CRC, corrupted by flip.
  function automatic logic [223:0] make_frame(input logic [15:0] mg, input logic [7:0] ver,
                                              input logic [7:0] ty, input logic [31:0] feed,
                                              input logic [63:0] seq, input logic [63:0] ts,
                                              input logic [31:0] flip);
    logic [191:0] head;
    logic [31:0]  c;
    head = {mg, ver, ty, feed, seq, ts};
    c = '1;
    for (int i = 0; i < 24; i++) c = crc_step(c, head[191-8*i -: 8]);
    return {head, ~c ^ flip};
  endfunction

  // Advance the deframer by one byte; queue a result after the last position.
  function automatic void deframe_byte(input logic [7:0] b, input logic st);
    logic [4:0]    p;
    frame_result_t r;
    p = trk_pos;
    if (st || p > hfc_pkg::LAST_POS) p = '0;
    if (p == '0) trk_crc = '1;
    if (p < hfc_pkg::CRC_BYTES) trk_crc = crc_step(trk_crc, b);
    if (p < 2) trk_magic = {trk_magic[7:0], b};
    else if (p == 2) trk_ver = b;
    else if (p == 3) trk_type = b;
    else if (p < 8) trk_feed = {trk_feed[23:0], b};
    else if (p < 16) trk_seq = {trk_seq[55:0], b};
    else if (p < 24) trk_ts = {trk_ts[55:0], b};
    else trk_fcs = {trk_fcs[23:0], b};
    if (p != hfc_pkg::LAST_POS) begin
      trk_pos = p + 5'd1;
    end else begin
      trk_pos = '0;
      if (trk_magic != cfg_magic) r.code = hfc_pkg::ERR_MAGIC;
      else if (trk_ver != cfg_ver) r.code = hfc_pkg::ERR_VERSION;
      else if (!type_ok(cfg_types, trk_type)) r.code = hfc_pkg::ERR_TYPE;
      else if (~trk_crc != trk_fcs) r.code = hfc_pkg::ERR_CRC;
      else r.code = hfc_pkg::ERR_NONE;
      if (pin_en) r.code = pin_code;
      r.ok    = (r.code == hfc_pkg::ERR_NONE);
      r.mtype = trk_type;
      r.feed  = trk_feed;
      r.seq   = trk_seq;
      r.ts    = trk_ts;
      r.fcs   = trk_fcs;
      pending_frames.push_back(r);
    end
  endfunction

  function automatic void flag(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] result %0d %s: expected %h, got %h", $time, frames_seen, what, want, got);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic st);
    int unsigned k;
    k = tx_idle ? $urandom_range(0, 7) : 0;
    if (k > 0) begin
      in_valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    frame_start <= st;
    do @(posedge clk); while (!in_ready);
    deframe_byte(b, st);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [223:0] f, input logic mark);
    for (int i = 0; i < 28; i++) push_byte(f[223-8*i -: 8], (i == 0) ? mark : 1'b0);
  endtask

  task automatic send_row(input dir_row_t r);
    for (int i = 0; i < r.cut; i++) push_byte(8'($urandom), i == 0);
    pin_en   = r.pinned;
    pin_code = r.code;
    send_frame(make_frame(r.mg, r.ver, r.ty, r.feed, r.seq, r.ts, r.flip), r.mark);
    pin_en = 1'b0;
  endtask

  // kind < 60 is a clean frame; higher values pick a fault or noise.
  task automatic send_random_frame(input int unsigned kind);
    logic [15:0] mg;
    logic [7:0]  ver;
    logic [7:0]  ty;
    logic [31:0] flip;
    logic        mark;
    int unsigned n;
    mg   = cfg_magic;
    ver  = cfg_ver;
    ty   = cfg_types[8*$urandom_range(0, hfc_pkg::NUM_TYPES-1) +: 8];
    flip = '0;
    mark = !(trk_pos == '0 && $urandom_range(0, 7) == 0);
    if (kind >= 92) begin
      n = $urandom_range(1, 40);
      repeat (n) push_byte(8'($urandom), $urandom_range(0, 7) == 0);
    end else if (kind >= 86) begin
      // drop a partial frame; the next frame restarts it
      n = $urandom_range(1, 27);
      for (int i = 0; i < n; i++) push_byte(8'($urandom), i == 0);
    end else begin
      if (kind >= 78) begin
        flip = $urandom_range(0, 1) ? (32'h1 << $urandom_range(0, 31)) : 32'($urandom);
        if (flip == '0) flip = 32'h1;
      end else if (kind >= 72) begin
        do ty = 8'($urandom); while (type_ok(cfg_types, ty));
      end else if (kind >= 66) begin
        ver = ver ^ 8'($urandom_range(1, 255));
      end else if (kind >= 60) begin
        mg = mg ^ 16'($urandom_range(1, 65535));
      end
      send_frame(make_frame(mg, ver, ty, 32'($urandom), {$urandom, $urandom},
                            {$urandom, $urandom}, flip), mark);
    end
  endtask

  task automatic run_random(input int unsigned budget);
    int unsigned first;
    first = bytes_sent;
    while (bytes_sent - first < budget) send_random_frame($urandom_range(0, 99));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending_frames.size() == 0);
    @(posedge clk);
    drains_done++;
  endtask

  task automatic write_reg(input hfc_pkg::cfg_index_t idx,
                           input logic [hfc_pkg::TYPES_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hfc_pkg::CFG_MAGIC:   cfg_magic = val[15:0];
      hfc_pkg::CFG_VERSION: cfg_ver   = val[7:0];
      hfc_pkg::CFG_TYPES:   cfg_types = val;
      default: ;
    endcase
  endtask

  // Write all registers once the block has gone quiet; junk rides in unused bits.
  task automatic set_regs(input logic [15:0] mg, input logic [7:0] ver,
                          input logic [hfc_pkg::TYPES_W-1:0] types);
    logic [39:0] junk;
    in_valid <= 1'b0;
    wait (pending_frames.size() == 0);
    repeat (4) @(posedge clk);
    junk = 40'({$urandom, $urandom});
    write_reg(hfc_pkg::CFG_MAGIC, {junk[39:16], mg});
    write_reg(hfc_pkg::CFG_VERSION, {junk[31:0], ver});
    write_reg(hfc_pkg::CFG_TYPES, types);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Result consumer: random stalls, plus long hold-offs on request.
  initial begin
    int unsigned k;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        holds_done++;
      end else begin
        k = rx_idle ? $urandom_range(0, 7) : 0;
        if (k > 0) begin
          out_ready <= 1'b0;
          repeat (k) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && hold_cycles == 0);
    end
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      frames_seen++;
      if (pending_frames.size() == 0) begin
        flag("result with nothing pending", '0, '0);
      end else begin
        want = pending_frames.pop_front();
        code_count[want.code]++;
        if (frame_ok !== want.ok) flag("frame_ok", 64'(want.ok), 64'(frame_ok));
        if (error_code !== want.code)
          flag("error_code", 64'(want.code), 64'(error_code));
        if (msg_type !== want.mtype) flag("msg_type", 64'(want.mtype), 64'(msg_type));
        if (feed_id !== want.feed) flag("feed_id", 64'(want.feed), 64'(feed_id));
        if (sequence_res !== want.seq) flag("sequence_res", want.seq, sequence_res);
        if (timestamp_res !== want.ts) flag("timestamp_res", want.ts, timestamp_res);
        if (frame_crc !== want.fcs) flag("frame_crc", 64'(want.fcs), 64'(frame_crc));
      end
    end
  end

  initial begin
    logic [7:0] dup;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    data_byte   <= '0;
    frame_start <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= hfc_pkg::CFG_MAGIC;
    cfg_data    <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_row(dir_rows[i]);

    set_regs(16'hFFFF, 8'hFF, {hfc_pkg::TYPES_W{1'b1}});
    run_random(PHASE_BYTES);

    set_regs(16'h0000, 8'h00, '0);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_random(PHASE_BYTES);

    dup = 8'($urandom);
    set_regs(16'($urandom), 8'($urandom),
             {dup, 8'($urandom), dup, 8'($urandom), 8'($urandom)});
    tx_idle = 1'b1;
    run_random(PHASE_BYTES);

    set_regs(16'($urandom), 8'($urandom), {8'($urandom), $urandom});
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    run_random(PHASE_BYTES);

    // Back to reset values; stall the consumer so the input backs up.
    set_regs(hfc_pkg::MAGIC_RESET, hfc_pkg::VERSION_RESET, hfc_pkg::TYPES_RESET);
    hold_cycles = 400;
    repeat (4) send_random_frame(0);
    tx_idle = 1'b1;
    repeat (2) send_random_frame(0);
    drain();
    repeat (2) send_random_frame(0);
    run_random(PHASE_BYTES);

    in_valid <= 1'b0;
    wait (pending_frames.size() == 0);
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes, checked %0d frame results over %0d register settings.",
             bytes_sent, frames_seen, settings_used);
    $display("Codes: ok %0d magic %0d version %0d type %0d crc %0d; %0d hold-offs, %0d drains.",
             code_count[hfc_pkg::ERR_NONE], code_count[hfc_pkg::ERR_MAGIC],
             code_count[hfc_pkg::ERR_VERSION], code_count[hfc_pkg::ERR_TYPE],
             code_count[hfc_pkg::ERR_CRC], holds_done, drains_done);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: heartbeat_frame_checker_core.f
+incdir+hw/rtl
hw/rtl/hfc_pkg.sv
hw/rtl/heartbeat_frame_checker_core.sv
hw/rtl/hfc_checker.sv
tb/heartbeat_frame_checker_core_tb.sv
